// ===== hw/rtl/qbez_pkg.sv =====
// Shared constants and types for the quadratic Bezier point evaluator.
package qbez_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int T_FRAC_BITS_DEF = 16;
   localparam int SEG_WIDTH_DEF   = 10;

   localparam int NUM_POINTS = 3;
   localparam int NUM_AXES   = 3;

   typedef struct packed {
      logic valid;
      logic zero_total;
   } ctrl_type;

endpackage

// ===== hw/rtl/qbez_div.sv =====
// Pipelined restoring divider producing t = index / total in unsigned fixed point.
module qbez_div #(
   parameter int SEG_WIDTH   = qbez_pkg::SEG_WIDTH_DEF,
   parameter int T_FRAC_BITS = qbez_pkg::T_FRAC_BITS_DEF,
   parameter int DATA_WIDTH  = qbez_pkg::NUM_POINTS * qbez_pkg::NUM_AXES
                               * qbez_pkg::COORD_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  qbez_pkg::ctrl_type      in_ctrl,
   input  logic [SEG_WIDTH-1:0]    in_index,
   input  logic [SEG_WIDTH-1:0]    in_total,
   input  logic [DATA_WIDTH-1:0]   in_data,
   output qbez_pkg::ctrl_type      out_ctrl,
   output logic [T_FRAC_BITS:0]    out_quot,
   output logic [DATA_WIDTH-1:0]   out_data
);

   localparam int NSTAGE = T_FRAC_BITS + 1;

   qbez_pkg::ctrl_type          ctrl_in [NSTAGE];
   qbez_pkg::ctrl_type          ctrl_ff [NSTAGE];
   logic [SEG_WIDTH-1:0]        rem_in  [NSTAGE];
   logic [SEG_WIDTH-1:0]        rem_ff  [NSTAGE];
   logic [SEG_WIDTH-1:0]        tot_in  [NSTAGE];
   logic [SEG_WIDTH-1:0]        tot_ff  [NSTAGE];
   logic [T_FRAC_BITS:0]        quot_in [NSTAGE];
   logic [T_FRAC_BITS:0]        quot_ff [NSTAGE];
   logic [DATA_WIDTH-1:0]       data_in [NSTAGE];
   logic [DATA_WIDTH-1:0]       data_ff [NSTAGE];

   genvar k;
   generate
      for (k = 0; k < NSTAGE; k++) begin : g_stage
         if (k == 0) begin : g_first
            logic ge;
            // saturate the index at the total: the top quotient bit absorbs it
            assign ge         = (in_index >= in_total);
            assign rem_in[k]  = ge ? '0 : in_index;
            assign quot_in[k] = {{T_FRAC_BITS{1'b0}}, ge};
            assign tot_in[k]  = in_total;
            assign ctrl_in[k] = in_ctrl;
            assign data_in[k] = in_data;
         end else begin : g_next
            logic [SEG_WIDTH:0] dbl;
            logic [SEG_WIDTH:0] diff;
            logic               ge;
            assign dbl        = {rem_ff[k-1], 1'b0};
            assign diff       = dbl - {1'b0, tot_ff[k-1]};
            assign ge         = (dbl >= {1'b0, tot_ff[k-1]});
            assign rem_in[k]  = ge ? diff[SEG_WIDTH-1:0] : dbl[SEG_WIDTH-1:0];
            assign quot_in[k] = {quot_ff[k-1][T_FRAC_BITS-1:0], ge};
            assign tot_in[k]  = tot_ff[k-1];
            assign ctrl_in[k] = ctrl_ff[k-1];
            assign data_in[k] = data_ff[k-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               ctrl_ff[k] <= '0;
            end else begin
               ctrl_ff[k] <= ctrl_in[k];
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[k]  <= rem_in[k];
            tot_ff[k]  <= tot_in[k];
            quot_ff[k] <= quot_in[k];
            data_ff[k] <= data_in[k];
         end
      end
   endgenerate

   assign out_ctrl = ctrl_ff[NSTAGE-1];
   assign out_quot = quot_ff[NSTAGE-1];
   assign out_data = data_ff[NSTAGE-1];

endmodule

// ===== hw/rtl/qbez_weight.sv =====
// Bernstein weight stages: u = 1 - t, then u*u, 2*u*t and t*t.
module qbez_weight #(
   parameter int T_FRAC_BITS = qbez_pkg::T_FRAC_BITS_DEF,
   parameter int DATA_WIDTH  = qbez_pkg::NUM_POINTS * qbez_pkg::NUM_AXES
                               * qbez_pkg::COORD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  qbez_pkg::ctrl_type          in_ctrl,
   input  logic [T_FRAC_BITS:0]        in_t,
   input  logic [DATA_WIDTH-1:0]       in_data,
   output qbez_pkg::ctrl_type          out_ctrl,
   output logic [2*T_FRAC_BITS:0]      out_w_start,
   output logic [2*T_FRAC_BITS:0]      out_w_ctrl,
   output logic [2*T_FRAC_BITS:0]      out_w_end,
   output logic [DATA_WIDTH-1:0]       out_data
);

   localparam int WW = 2 * T_FRAC_BITS + 1;
   localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS + 1)'(1) << T_FRAC_BITS;

   qbez_pkg::ctrl_type        ctrl_a_in, ctrl_a_ff, ctrl_b_in, ctrl_b_ff;
   logic [T_FRAC_BITS:0]      t_in, t_ff, u_in, u_ff;
   logic [DATA_WIDTH-1:0]     data_a_in, data_a_ff, data_b_in, data_b_ff;
   logic [WW:0]               uu, ut, tt;
   logic [WW-1:0]             ws_in, ws_ff, wc_in, wc_ff, we_in, we_ff;

   assign ctrl_a_in = in_ctrl;
   assign data_a_in = in_data;
   assign t_in      = in_t;
   assign u_in      = T_ONE - in_t;

   assign uu = u_ff * u_ff;
   assign ut = u_ff * t_ff;
   assign tt = t_ff * t_ff;

   assign ctrl_b_in = ctrl_a_ff;
   assign data_b_in = data_a_ff;
   assign ws_in     = uu[WW-1:0];
   assign wc_in     = {ut[WW-2:0], 1'b0};
   assign we_in     = tt[WW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff <= '0;
         ctrl_b_ff <= '0;
      end else begin
         ctrl_a_ff <= ctrl_a_in;
         ctrl_b_ff <= ctrl_b_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      u_ff      <= u_in;
      data_a_ff <= data_a_in;
      ws_ff     <= ws_in;
      wc_ff     <= wc_in;
      we_ff     <= we_in;
      data_b_ff <= data_b_in;
   end

   assign out_ctrl    = ctrl_b_ff;
   assign out_w_start = ws_ff;
   assign out_w_ctrl  = wc_ff;
   assign out_w_end   = we_ff;
   assign out_data    = data_b_ff;

endmodule

// ===== hw/rtl/qbez_mix.sv =====
// Weighted sum of the three control points per axis, floor shift and result register.
module qbez_mix #(
   parameter int COORD_WIDTH = qbez_pkg::COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = qbez_pkg::T_FRAC_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  qbez_pkg::ctrl_type                               in_ctrl,
   input  logic [2*T_FRAC_BITS:0]                           in_w_start,
   input  logic [2*T_FRAC_BITS:0]                           in_w_ctrl,
   input  logic [2*T_FRAC_BITS:0]                           in_w_end,
   input  logic [qbez_pkg::NUM_POINTS*qbez_pkg::NUM_AXES*COORD_WIDTH-1:0] in_data,
   output qbez_pkg::ctrl_type                               out_ctrl,
   output logic [qbez_pkg::NUM_AXES*COORD_WIDTH-1:0]        out_coord
);

   localparam int NAX  = qbez_pkg::NUM_AXES;
   localparam int NEL  = qbez_pkg::NUM_POINTS * NAX;
   localparam int WW   = 2 * T_FRAC_BITS + 1;
   localparam int PW   = WW + 1 + COORD_WIDTH;
   localparam int SW   = PW + 2;
   localparam int SH   = 2 * T_FRAC_BITS;

   qbez_pkg::ctrl_type              ctrl_m_in, ctrl_m_ff, ctrl_s_in, ctrl_s_ff;
   logic signed [PW-1:0]            prod_in  [NEL];
   logic signed [PW-1:0]            prod_ff  [NEL];
   logic [NAX*COORD_WIDTH-1:0]      start_in, start_ff;
   logic [NAX*COORD_WIDTH-1:0]      coord_in, coord_ff;

   assign ctrl_m_in = in_ctrl;
   assign start_in  = in_data[NAX*COORD_WIDTH-1:0];

   genvar i, a;
   generate
      for (i = 0; i < NEL; i++) begin : g_prod
         localparam int GRP = i / NAX;
         logic [WW-1:0] w;
         if (GRP == 0) begin : g_ws
            assign w = in_w_start;
         end else if (GRP == 1) begin : g_wc
            assign w = in_w_ctrl;
         end else begin : g_we
            assign w = in_w_end;
         end
         assign prod_in[i] = $signed({1'b0, w})
                             * $signed(in_data[i*COORD_WIDTH +: COORD_WIDTH]);
      end

      for (a = 0; a < NAX; a++) begin : g_axis
         logic signed [SW-1:0] sum;
         assign sum = SW'(prod_ff[a]) + SW'(prod_ff[NAX+a]) + SW'(prod_ff[2*NAX+a]);
         // floor shift is a plain bit slice of the two's complement sum
         assign coord_in[a*COORD_WIDTH +: COORD_WIDTH] =
            ctrl_m_ff.zero_total ? start_ff[a*COORD_WIDTH +: COORD_WIDTH]
                                 : sum[SH +: COORD_WIDTH];
      end
   endgenerate

   assign ctrl_s_in = ctrl_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_m_ff <= '0;
         ctrl_s_ff <= '0;
      end else begin
         ctrl_m_ff <= ctrl_m_in;
         ctrl_s_ff <= ctrl_s_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      start_ff <= start_in;
      coord_ff <= coord_in;
   end

   assign out_ctrl  = ctrl_s_ff;
   assign out_coord = coord_ff;

endmodule

// ===== hw/rtl/quadratic_bezier_point.sv =====
// Top level of the 3D quadratic Bezier point evaluator.
//
//   channel   ports                      transfer
//   request   start, busy, req_*         start high and busy low at a clock edge
//   response  rsp_valid, rsp_*           rsp_valid high for one cycle, no back-pressure
//
// T_FRAC_BITS + 1 divider stages, two weight stages and two blend stages make up the pipeline.
// A new transaction may start every cycle.
// busy is high only while reset is held; reset clears the valid bits of every stage.
// Results cannot be stalled, so the pipeline never holds.
module quadratic_bezier_point #(
   parameter int COORD_WIDTH = qbez_pkg::COORD_WIDTH_DEF,
   parameter int T_FRAC_BITS = qbez_pkg::T_FRAC_BITS_DEF,
   parameter int SEG_WIDTH   = qbez_pkg::SEG_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_x,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_y,
   input  logic signed [COORD_WIDTH-1:0] req_ctrl_z,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_z,
   input  logic        [SEG_WIDTH-1:0]   req_seg_index,
   input  logic        [SEG_WIDTH-1:0]   req_seg_total,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_zero_total_error
);

   localparam int NAX        = qbez_pkg::NUM_AXES;
   localparam int DATA_WIDTH = qbez_pkg::NUM_POINTS * NAX * COORD_WIDTH;
   localparam int LATENCY    = T_FRAC_BITS + 5;

   qbez_pkg::ctrl_type             req_ctrl, div_ctrl, wgt_ctrl, mix_ctrl;
   logic [DATA_WIDTH-1:0]          req_data, div_data, wgt_data;
   logic [T_FRAC_BITS:0]           div_t;
   logic [2*T_FRAC_BITS:0]         w_start, w_ctrl, w_end;
   logic [NAX*COORD_WIDTH-1:0]     mix_coord;

   assign busy = reset;

   assign req_ctrl.valid      = start & ~busy;
   assign req_ctrl.zero_total = (req_seg_total == '0);
   assign req_data = {req_end_z, req_end_y, req_end_x,
                      req_ctrl_z, req_ctrl_y, req_ctrl_x,
                      req_start_z, req_start_y, req_start_x};

   qbez_div #(
      .SEG_WIDTH   (SEG_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_ctrl  (req_ctrl),
      .in_index (req_seg_index),
      .in_total (req_seg_total),
      .in_data  (req_data),
      .out_ctrl (div_ctrl),
      .out_quot (div_t),
      .out_data (div_data)
   );

   qbez_weight #(
      .T_FRAC_BITS (T_FRAC_BITS),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_weight (
      .clock       (clock),
      .reset       (reset),
      .in_ctrl     (div_ctrl),
      .in_t        (div_t),
      .in_data     (div_data),
      .out_ctrl    (wgt_ctrl),
      .out_w_start (w_start),
      .out_w_ctrl  (w_ctrl),
      .out_w_end   (w_end),
      .out_data    (wgt_data)
   );

   qbez_mix #(
      .COORD_WIDTH (COORD_WIDTH),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_mix (
      .clock      (clock),
      .reset      (reset),
      .in_ctrl    (wgt_ctrl),
      .in_w_start (w_start),
      .in_w_ctrl  (w_ctrl),
      .in_w_end   (w_end),
      .in_data    (wgt_data),
      .out_ctrl   (mix_ctrl),
      .out_coord  (mix_coord)
   );

   assign rsp_valid            = mix_ctrl.valid;
   assign rsp_zero_total_error = mix_ctrl.zero_total;
   assign rsp_out_x            = mix_coord[0*COORD_WIDTH +: COORD_WIDTH];
   assign rsp_out_y            = mix_coord[1*COORD_WIDTH +: COORD_WIDTH];
   assign rsp_out_z            = mix_coord[2*COORD_WIDTH +: COORD_WIDTH];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy, LATENCY))
      else $error("response strobe does not follow its transaction by the pipeline latency");

   a_zero_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_total_error |-> rsp_out_x == $past(req_start_x, LATENCY))
      else $error("zero total did not return the start point");

   a_t_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_seg_total != '0 && req_seg_index >= req_seg_total, LATENCY)
      |-> rsp_out_z == $past(req_end_z, LATENCY))
      else $error("saturated index did not return the end point");

   a_t_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_seg_total != '0 && req_seg_index == '0, LATENCY)
      |-> rsp_out_y == $past(req_start_y, LATENCY) && !rsp_zero_total_error)
      else $error("index zero did not return the start point");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the quadratic Bezier point evaluator.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW      = qbez_pkg::COORD_WIDTH_DEF;
   localparam int TF      = qbez_pkg::T_FRAC_BITS_DEF;
   localparam int SW      = qbez_pkg::SEG_WIDTH_DEF;
   localparam int LATENCY = TF + 5;

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [SW-1:0]        SMAX = {SW{1'b1}};

   typedef struct packed {
      logic signed [CW-1:0] sx, sy, sz;
      logic signed [CW-1:0] cx, cy, cz;
      logic signed [CW-1:0] ex, ey, ez;
      logic [SW-1:0]        idx;
      logic [SW-1:0]        tot;
   } curve_req_type;

   typedef struct packed {
      logic signed [CW-1:0] x, y, z;
      logic                 err;
   } curve_point_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [CW-1:0] req_start_x = '0, req_start_y = '0, req_start_z = '0;
   logic signed [CW-1:0] req_ctrl_x = '0, req_ctrl_y = '0, req_ctrl_z = '0;
   logic signed [CW-1:0] req_end_x = '0, req_end_y = '0, req_end_z = '0;
   logic [SW-1:0]        req_seg_index = '0, req_seg_total = '0;
   logic                 rsp_valid;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic                 rsp_zero_total_error;

   curve_point_type expected_points[$];
   int unsigned     mismatch_count = 0;

   quadratic_bezier_point dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_start_z(req_start_z),
      .req_ctrl_x(req_ctrl_x), .req_ctrl_y(req_ctrl_y), .req_ctrl_z(req_ctrl_z),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .req_end_z(req_end_z),
      .req_seg_index(req_seg_index), .req_seg_total(req_seg_total),
      .rsp_valid(rsp_valid), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_zero_total_error(rsp_zero_total_error)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #2_400_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic signed [CW-1:0] blend_axis(longint ws, longint wc, longint we,
                                                        longint s, longint c, longint e);
      longint acc;
      acc = ws * s + wc * c + we * e;
      return CW'(acc >>> (2 * TF));
   endfunction

   function automatic curve_point_type eval_point(curve_req_type r);
      curve_point_type p;
      longint          idx, t, u;
      if (r.tot == '0) begin
         p.x   = r.sx;
         p.y   = r.sy;
         p.z   = r.sz;
         p.err = 1'b1;
      end else begin
         idx   = (r.idx > r.tot) ? longint'(r.tot) : longint'(r.idx);
         t     = (idx << TF) / longint'(r.tot);
         u     = (longint'(1) << TF) - t;
         p.x   = blend_axis(u * u, 2 * u * t, t * t, r.sx, r.cx, r.ex);
         p.y   = blend_axis(u * u, 2 * u * t, t * t, r.sy, r.cy, r.ey);
         p.z   = blend_axis(u * u, 2 * u * t, t * t, r.sz, r.cz, r.ez);
         p.err = 1'b0;
      end
      return p;
   endfunction

   function automatic logic signed [CW-1:0] rand_coord();
      unique case ($urandom_range(0, 9))
         0: return CMAX;
         1: return CMIN;
         2: return CW'($signed($urandom_range(0, 15)) - 8);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic curve_req_type rand_curve();
      curve_req_type r;
      int unsigned   pick;
      r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
      r.cx = rand_coord(); r.cy = rand_coord(); r.cz = rand_coord();
      r.ex = rand_coord(); r.ey = rand_coord(); r.ez = rand_coord();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         r.tot = ($urandom_range(0, 3) == 0) ? SW'($urandom_range(1, 8))
                                             : SW'($urandom_range(1, SMAX));
         r.idx = SW'($urandom_range(0, r.tot));
      end else if (pick < 90) begin
         r.tot = SW'($urandom_range(1, SMAX - 1));
         r.idx = SW'($urandom_range(r.tot + 1, SMAX));
      end else begin
         r.tot = '0;
         r.idx = SW'($urandom);
      end
      return r;
   endfunction

   task automatic send_curve(curve_req_type r);
      req_start_x   <= r.sx; req_start_y <= r.sy; req_start_z <= r.sz;
      req_ctrl_x    <= r.cx; req_ctrl_y  <= r.cy; req_ctrl_z  <= r.cz;
      req_end_x     <= r.ex; req_end_y   <= r.ey; req_end_z   <= r.ez;
      req_seg_index <= r.idx;
      req_seg_total <= r.tot;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      expected_points.push_back(eval_point(r));
   endtask

   // y takes the inverted x values, z the halved ones
   task automatic send_axes(logic signed [CW-1:0] s, logic signed [CW-1:0] c,
                            logic signed [CW-1:0] e, logic [SW-1:0] idx,
                            logic [SW-1:0] tot);
      send_curve(curve_req_type'{s, ~s, s >>> 1, c, ~c, c >>> 1, e, ~e, e >>> 1, idx, tot});
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clock);
   endtask

   task automatic check_field(string name, longint expv, longint actv);
      if (expv != actv) begin
         $error("%s: expected %0d, actual %0d", name, expv, actv);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      curve_point_type exp_pt;
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            $error("unexpected transaction: x %0d y %0d z %0d err %0b",
                   rsp_out_x, rsp_out_y, rsp_out_z, rsp_zero_total_error);
            mismatch_count++;
         end else begin
            exp_pt = expected_points.pop_front();
            check_field("out_x", exp_pt.x, rsp_out_x);
            check_field("out_y", exp_pt.y, rsp_out_y);
            check_field("out_z", exp_pt.z, rsp_out_z);
            check_field("zero_total_error", longint'(exp_pt.err),
                        longint'(rsp_zero_total_error));
         end
      end
   end

   task automatic test_extremes();
      send_axes(CMAX, CMAX, CMAX, 1, 2);
      send_axes(CMIN, CMIN, CMIN, 1, 2);
      send_axes(CMIN, CMAX, CMIN, 1, 3);
      send_axes(CMAX, CMIN, CMAX, 511, SMAX);
      send_axes(CMIN, CMAX, CMAX, 1, SMAX);
      send_axes(CMAX, CMIN, CMIN, SMAX - 1, SMAX);
      send_axes(0, -1, 1, 2, 3);
      send_axes(-1, -1, -1, 1, 7);
      send_axes(CMIN, 0, CMAX, 2, 5);
   endtask

   task automatic test_special_cases();
      send_axes(CMAX, CMIN, 5, 0, 1);
      send_axes(CMIN, CMAX, -5, SMAX, SMAX);
      send_axes(100, 200, CMIN, SMAX, 1);
      send_axes(-300, CMAX, 77, 5, 4);
      send_axes(CMAX, 0, CMIN, SMAX, SMAX - 1);
      send_axes(CMIN, CMAX, CMAX, 0, 0);
      send_axes(CMAX, CMIN, CMIN, SMAX, 0);
      send_axes(-1, CMAX, CMIN, 512, 0);
      send_axes(1234, -5678, 91011, 0, SMAX);
   endtask

   task automatic test_random_points(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_curve(rand_curve());
         if ((i / 64) % 3 != 2 && $urandom_range(0, 3) == 0) idle_burst();
      end
   endtask

   task automatic test_back_to_back(int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_curve(rand_curve());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_special_cases();
      test_random_points(1100);
      test_back_to_back(200);
      start <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/qbez_pkg.sv
hw/rtl/qbez_div.sv
hw/rtl/qbez_weight.sv
hw/rtl/qbez_mix.sv
hw/rtl/quadratic_bezier_point.sv
verif/tb_top.sv
